// File: rtl/core/ipw_pkg.sv
`timescale 1ns / 1ps
package ipw_pkg;

   localparam int BYTE_W   = 8;
   localparam int HALF_W   = 16;
   // Datapath widths sized for the largest image (side 256, 196608 bytes)
   localparam int MAG_W    = 26;             // |N*x - S|
   localparam int D_W      = 52;             // N*Q - S*S with floor
   localparam int Q_W      = 34;             // floor(v * 2^25), v < 2^9
   localparam int FRAC_SH  = 50;             // 2 * 25 fraction bits
   localparam int DP_W     = 122;            // remainder and delta width
   localparam int B_SH     = 2 * (Q_W - 1);  // D * 4^(Q_W-1)
   localparam int BIT_W    = 6;
   localparam int SH_W     = 5;
   localparam int FLOOR_K  = 65025;          // 255 * 255

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_STAT_MUL,
      S_STAT_SET,
      S_FETCH,
      S_SCALE,
      S_WAIT
   } top_state_type;

   typedef enum logic [2:0] {
      U_IDLE,
      U_SQUARE,
      U_ITER,
      U_ROUND,
      U_DONE
   } unit_state_type;

   typedef struct packed {
      logic start;
      logic ack;
   } unit_ctl_type;

endpackage

// File: rtl/core/ipw_ram.sv
`timescale 1ns / 1ps
module ipw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/core/ipw_div.sv
`timescale 1ns / 1ps
module ipw_div (
   input  logic                      clock,
   input  logic                      reset,
   input  ipw_pkg::unit_ctl_type     ctl,
   input  logic [ipw_pkg::MAG_W-1:0] mag,
   input  logic                      neg,
   input  logic [ipw_pkg::D_W-1:0]   dval,
   output logic                      done,
   output logic [ipw_pkg::HALF_W-1:0] half
);
   import ipw_pkg::*;

   unit_state_type    state_ff, state_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              neg_ff, neg_in;
   logic [DP_W-1:0]   r_ff, r_in;
   logic [DP_W-1:0]   a_ff, a_in;
   logic [DP_W-1:0]   b_ff, b_in;
   logic [Q_W-1:0]    q_ff, q_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [BIT_W-1:0]  top_ff, top_in;
   logic              found_ff, found_in;
   logic [HALF_W-1:0] half_ff, half_in;

   logic [DP_W-1:0]    delta;
   logic [2*MAG_W-1:0] mag_sq;
   logic               sub;
   logic [SH_W-1:0]    sh;
   logic [SH_W-1:0]    ebase;
   logic [Q_W-1:0]     shifted;
   logic [Q_W-1:0]     low_mask;
   logic               guard;
   logic               sticky;
   logic               rnd;
   logic [14:0]        mant;

   assign mag_sq = mag_ff * mag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      r_ff     <= r_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      q_ff     <= q_in;
      bit_ff   <= bit_in;
      top_ff   <= top_in;
      found_ff <= found_in;
      half_ff  <= half_in;
   end

   // Rounding of floor(v * 2^25) plus remainder to binary16
   always_comb begin
      sub      = !found_ff || (top_ff < BIT_W'(11));
      sh       = sub ? SH_W'(1) : SH_W'(top_ff - BIT_W'(10));
      ebase    = sub ? SH_W'(0) : SH_W'(top_ff - BIT_W'(11));
      shifted  = q_ff >> sh;
      guard    = q_ff[BIT_W'(sh) - BIT_W'(1)];
      low_mask = (Q_W'(1) << (sh - SH_W'(1))) - Q_W'(1);
      sticky   = ((q_ff & low_mask) != '0) || (r_ff != '0);
      rnd      = guard & (sticky | shifted[0]);
      mant     = {ebase, 10'd0} + 15'(shifted) + 15'(rnd);
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      r_in     = r_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      q_in     = q_ff;
      bit_in   = bit_ff;
      top_in   = top_ff;
      found_in = found_ff;
      half_in  = half_ff;
      delta    = a_ff + b_ff;
      done     = 1'b0;
      unique case (state_ff)
         U_IDLE: begin
            if (ctl.start) begin
               mag_in   = mag;
               neg_in   = neg;
               a_in     = '0;
               b_in     = DP_W'(dval) << B_SH;
               q_in     = '0;
               bit_in   = BIT_W'(Q_W - 1);
               found_in = 1'b0;
               top_in   = '0;
               state_in = U_SQUARE;
            end
         end
         U_SQUARE: begin
            r_in     = DP_W'(mag_sq) << FRAC_SH;
            state_in = U_ITER;
         end
         U_ITER: begin
            // Try one more root bit: (Q + 2^b)^2 * D against the remainder
            if (delta <= r_ff) begin
               r_in         = r_ff - delta;
               a_in         = (a_ff >> 1) + b_ff;
               q_in[bit_ff] = 1'b1;
               if (!found_ff) begin
                  found_in = 1'b1;
                  top_in   = bit_ff;
               end
            end else begin
               a_in = a_ff >> 1;
            end
            b_in = b_ff >> 2;
            if (bit_ff == '0) begin
               state_in = U_ROUND;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end
         U_ROUND: begin
            half_in  = {neg_ff && (mant != '0), mant};
            state_in = U_DONE;
         end
         U_DONE: begin
            done = 1'b1;
            if (ctl.ack) begin
               state_in = U_IDLE;
            end
         end
         default: state_in = U_IDLE;
      endcase
   end

   assign half = half_ff;

endmodule

// File: rtl/core/image_prewhiten_fp16.sv
`timescale 1ns / 1ps
// Per-image standardization of a square, interleaved three-channel byte image, with
// results as IEEE binary16. Load beats (tuser = 0) write one byte a cycle, while no
// read is in progress, into the pixel store and add it to the running sum and sum of
// squares; bytes beyond N = 3 * side * side are dropped. A read beat (tuser = 1)
// before the image is complete is taken and gives nothing. Each read beat afterwards
// returns the next element as (N*x - S) / sqrt(D), D = max(N*Q - S*S, 65025*N),
// rounded to nearest even, with the first and third channel of every pixel swapped;
// tlast marks element N-1, after which the image state clears for the next image.
// On the first read of an image the statistics are latched first (S_STAT_MUL, S_STAT_SET).
// Each read passes through one store read, one scale, one squaring, 34 steps of the
// bit-serial root-and-divide unit, one rounding and one output beat; a new beat is
// taken only once the result is in the output register. Writing the side register
// (0 counts as 1, values above MAX_SIDE saturate) also clears the image state.
module image_prewhiten_fp16 #(
   parameter int MAX_SIDE = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,   // image_side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] pixel_byte
   input  logic        req_tuser,     // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [15:0] half_value
   output logic        rsp_tlast
);
   import ipw_pkg::*;

   localparam int DEPTH      = 3 * MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
   localparam int SUM_W      = CNT_W + 8;
   localparam int SQ_W       = CNT_W + 16;
   localparam int NQ_W       = 2 * CNT_W + 16;
   localparam int RESET_SIDE = (MAX_SIDE < 128) ? MAX_SIDE : 128;
   localparam int RESET_N    = 3 * RESET_SIDE * RESET_SIDE;

   top_state_type     state_ff, state_in;
   logic [SIDE_W-1:0] side_ff, side_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [CNT_W-1:0]  load_ff, load_in;
   logic [CNT_W-1:0]  read_ff, read_in;
   logic [CNT_W-1:0]  base_ff, base_in;
   logic [1:0]        chan_ff, chan_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [SUM_W-1:0]  mean_ff, mean_in;
   logic [D_W-1:0]    dev_ff, dev_in;
   logic              stats_ff, stats_in;
   logic [NQ_W-1:0]   nq_ff, nq_in;
   logic [NQ_W-1:0]   ss_ff, ss_in;
   logic [NQ_W-1:0]   fl_ff, fl_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [HALF_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_we;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;
   logic [SIDE_W-1:0] side_new;
   logic [NQ_W-1:0]   var_raw;
   logic [SUM_W-1:0]  nx;
   logic              neg;
   logic [SUM_W-1:0]  mag;
   logic              last;
   logic              div_done;
   logic [HALF_W-1:0] div_half;
   unit_ctl_type      ctl;

   ipw_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(load_ff)),
      .wr_data (req_tdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   ipw_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .mag   (MAG_W'(mag)),
      .neg   (neg),
      .dval  (dev_ff),
      .done  (div_done),
      .half  (div_half)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         side_ff      <= SIDE_W'(RESET_SIDE);
         n_ff         <= CNT_W'(RESET_N);
         load_ff      <= '0;
         read_ff      <= '0;
         base_ff      <= '0;
         chan_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         mean_ff      <= '0;
         dev_ff       <= '0;
         stats_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         side_ff      <= side_in;
         n_ff         <= n_in;
         load_ff      <= load_in;
         read_ff      <= read_in;
         base_ff      <= base_in;
         chan_ff      <= chan_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         mean_ff      <= mean_in;
         dev_ff       <= dev_in;
         stats_ff     <= stats_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      nq_ff       <= nq_in;
      ss_ff       <= ss_in;
      fl_ff       <= fl_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Clamp the written side into 1..MAX_SIDE
   always_comb begin
      if (csr_wr_data == 8'd0) begin
         side_new = SIDE_W'(1);
      end else if (32'(csr_wr_data) > MAX_SIDE) begin
         side_new = SIDE_W'(MAX_SIDE);
      end else begin
         side_new = SIDE_W'(csr_wr_data);
      end
   end

   // Scale the fetched byte: N*x - S, split into magnitude and sign
   always_comb begin
      nx   = SUM_W'(n_ff) * SUM_W'(ram_rdata);
      neg  = nx < mean_ff;
      mag  = neg ? (mean_ff - nx) : (nx - mean_ff);
      last = (read_ff + CNT_W'(1)) >= n_ff;
   end

   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      n_in         = n_ff;
      load_in      = load_ff;
      read_in      = read_ff;
      base_in      = base_ff;
      chan_in      = chan_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      mean_in      = mean_ff;
      dev_in       = dev_ff;
      stats_in     = stats_ff;
      nq_in        = nq_ff;
      ss_in        = ss_ff;
      fl_in        = fl_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      // Swap channels: read pixel base + 2 - channel
      ram_raddr    = ADDR_W'(base_ff + CNT_W'(2) - CNT_W'(chan_ff));
      ctl          = '0;
      req_tready   = 1'b0;
      var_raw      = (nq_ff > ss_ff) ? (nq_ff - ss_ff) : '0;

      // Drop the output beat once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == OP_LOAD) begin
                  if (load_ff < n_ff) begin
                     ram_we  = 1'b1;
                     load_in = load_ff + CNT_W'(1);
                     sum_in  = sum_ff + SUM_W'(req_tdata);
                     sq_in   = sq_ff + SQ_W'(req_tdata) * SQ_W'(req_tdata);
                  end
               end else if (load_ff >= n_ff) begin
                  state_in = stats_ff ? S_FETCH : S_STAT_MUL;
               end
            end
         end
         S_STAT_MUL: begin
            nq_in    = NQ_W'(n_ff) * NQ_W'(sq_ff);
            ss_in    = NQ_W'(sum_ff) * NQ_W'(sum_ff);
            fl_in    = NQ_W'(n_ff) * NQ_W'(FLOOR_K);
            state_in = S_STAT_SET;
         end
         S_STAT_SET: begin
            mean_in  = sum_ff;
            dev_in   = D_W'((var_raw < fl_ff) ? fl_ff : var_raw);
            stats_in = 1'b1;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            ram_re   = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            ctl.start = 1'b1;
            state_in  = S_WAIT;
         end
         S_WAIT: begin
            // Hold the result in the unit until the output register is free
            if (div_done && (!rsp_valid_ff || rsp_tready)) begin
               ctl.ack      = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = div_half;
               rsp_last_in  = last;
               state_in     = S_IDLE;
               if (last) begin
                  load_in  = '0;
                  read_in  = '0;
                  base_in  = '0;
                  chan_in  = '0;
                  sum_in   = '0;
                  sq_in    = '0;
                  mean_in  = '0;
                  dev_in   = '0;
                  stats_in = 1'b0;
               end else begin
                  read_in = read_ff + CNT_W'(1);
                  if (chan_ff == 2'd2) begin
                     chan_in = '0;
                     base_in = base_ff + CNT_W'(3);
                  end else begin
                     chan_in = chan_ff + 2'd1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Side write: take the new size and clear the image
      if (csr_wr_en) begin
         side_in  = side_new;
         n_in     = CNT_W'(CNT_W'(side_new) * CNT_W'(side_new) * CNT_W'(3));
         load_in  = '0;
         read_in  = '0;
         base_in  = '0;
         chan_in  = '0;
         sum_in   = '0;
         sq_in    = '0;
         mean_in  = '0;
         dev_in   = '0;
         stats_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/core/ipw_checker.sv
`timescale 1ns / 1ps
module ipw_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled output beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("output beat changed while stalled");

   // Output is empty right after reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("output beat valid after reset");

   // Zero results are always positive zero
   a_no_negzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != 16'h8000)
      else $error("negative zero produced");

   // Results stay finite
   a_finite: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:10] != 5'h1F)
      else $error("infinite or NaN result");

endmodule

bind image_prewhiten_fp16 ipw_checker u_ipw_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
